@@ hdl/etl_pkg.sv @@
// Shared types, codes and saturating Q32.32 helpers for the enthalpy table core.
// Used by etl_unit and enthalpy_temperature_table_lookup_core; no dependencies.
`default_nettype none
package etl_pkg;

	localparam int TABLE_ENTRIES_DEF = 128;
	localparam int TEMP_W            = 45;
	localparam int VAL_W             = 64;
	localparam int KIND_W            = 2;
	localparam int REG_IDX_W         = 3;

	// Item kinds
	localparam logic [KIND_W-1:0] KIND_BUILD = 2'd0;
	localparam logic [KIND_W-1:0] KIND_INV   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FWD   = 2'd2;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_MELT = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_BOIL = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_CAPA = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CAPB = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_CAPC = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_CAPD = 3'd5;

	localparam logic signed [VAL_W-1:0] VAL_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [VAL_W-1:0] VAL_MIN   = 64'sh8000_0000_0000_0000;
	// ceil(2^65 / 3): floor(m / 3) is bits 127:65 of m times this
	localparam logic [VAL_W-1:0]        RECIP_THREE = 64'hAAAA_AAAA_AAAA_AAAB;

	typedef enum logic {OP_MUL, OP_DIV} unit_op_t;

	// Request to the shared multiply/divide unit
	typedef struct packed {
		logic          start;
		unit_op_t      op;
		logic [63:0]   mul_a;
		logic [63:0]   mul_b;
		logic [127:0]  dividend;
		logic [63:0]   divisor;
	} unit_req_t;

	// Response from the shared unit; prod and quot hold until the next start
	typedef struct packed {
		logic          done;
		logic [127:0]  prod;
		logic [63:0]   quot;
		logic          ovf;
	} unit_rsp_t;

	function automatic logic [63:0] magn(input logic signed [63:0] x);
		return x[63] ? (~x + 64'd1) : x;
	endfunction

	// Apply sign to a magnitude and saturate
	function automatic logic signed [63:0] sat_pack(input logic neg, input logic [63:0] m,
			input logic ovf);
		logic signed [63:0] r;
		if (neg) begin
			r = (ovf || m[63]) ? VAL_MIN : -$signed(m);
		end else begin
			r = (ovf || m[63]) ? VAL_MAX : $signed(m);
		end
		return r;
	endfunction

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		logic signed [63:0] r;
		s = 65'(a) + 65'(b);
		if (s[64] != s[63]) begin
			r = s[64] ? VAL_MIN : VAL_MAX;
		end else begin
			r = s[63:0];
		end
		return r;
	endfunction

	function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		logic signed [63:0] r;
		s = 65'(a) - 65'(b);
		if (s[64] != s[63]) begin
			r = s[64] ? VAL_MIN : VAL_MAX;
		end else begin
			r = s[63:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ hdl/etl_unit.sv @@
// Shared iterative arithmetic unit: 64x64 multiply from four 32x32 partial
// products, and 128/64 restoring division one bit a cycle. Depends on etl_pkg.
`default_nettype none
module etl_unit (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire etl_pkg::unit_req_t req,
	output etl_pkg::unit_rsp_t    rsp
);
	import etl_pkg::*;

	logic           busy_q;
	logic           done_q;
	unit_op_t       op_q;
	logic [6:0]     cnt_q;
	logic [63:0]    xa_q, xb_q;
	logic [63:0]    pp_q;
	logic [1:0]     shp_q;
	logic [127:0]   acc_q;
	logic [63:0]    den_q;
	logic [63:0]    rem_q;
	logic [127:0]   dvd_q;
	logic [63:0]    quot_q;
	logic           ovf_q;

	logic [64:0]    trial;
	logic           ge;
	logic [64:0]    diff;

	// Restoring division step
	assign trial = {rem_q, dvd_q[127]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (op_q == OP_MUL) begin
					if (cnt_q == 7'd4) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end else begin
					if (cnt_q == 7'd127) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	// Datapath: load operands, then multiply or divide
	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q   <= req.op;
			xa_q   <= req.mul_a;
			xb_q   <= req.mul_b;
			acc_q  <= '0;
			dvd_q  <= req.dividend;
			den_q  <= req.divisor;
			rem_q  <= '0;
			quot_q <= '0;
			ovf_q  <= 1'b0;
		end else if (busy_q) begin
			if (op_q == OP_MUL) begin
				if (cnt_q < 7'd4) begin
					pp_q  <= xa_q[cnt_q[1]*32 +: 32] * xb_q[cnt_q[0]*32 +: 32];
					shp_q <= 2'(cnt_q[1]) + 2'(cnt_q[0]);
				end
				if (cnt_q != 7'd0) begin
					acc_q <= acc_q + ({64'b0, pp_q} << {shp_q, 5'b0});
				end
			end else begin
				dvd_q  <= {dvd_q[126:0], 1'b0};
				rem_q  <= ge ? diff[63:0] : trial[63:0];
				quot_q <= {quot_q[62:0], ge & cnt_q[6]};
				ovf_q  <= ovf_q | (ge & ~cnt_q[6]);
			end
		end
	end

	assign rsp = {done_q, acc_q, quot_q, ovf_q};

endmodule
`default_nettype wire

@@ hdl/enthalpy_temperature_table_lookup_core.sv @@
// Enthalpy/temperature table core: config registers, table memory and sequencer.
// Depends on etl_pkg and etl_unit.
//
// One item at a time: start is taken while busy is low, and the single result
// appears on answer/answer_valid with a one-cycle done strobe that cannot be
// held off. All multiplies and divides run on one shared unit; the divisions by
// TABLE_ENTRIES and by three are reciprocal multiplies, and the halving is a
// shift. A forward query (temperature to enthalpy) evaluates the polynomial
// once (six multiplies and the c/t divide, which a zero temperature skips).
// An inverse query does a binary search, then two multiplies and one divide;
// a flat segment answers after the first multiply. A build multiplies for the
// step, then evaluates the polynomial for the offset and for each entry whose
// temperature lies below the boiling point; entries past that fill stop are
// written as zero. Queries on an empty table, unused kinds and builds with
// missing temperatures answer straight from idle with answer_valid low.
`default_nettype none
module enthalpy_temperature_table_lookup_core #(
	parameter int TABLE_ENTRIES = etl_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic [etl_pkg::KIND_W-1:0]           kind,
	input  wire logic signed [etl_pkg::VAL_W-1:0]     query_value,
	output logic                                      done,
	output logic signed [etl_pkg::VAL_W-1:0]          answer,
	output logic                                      answer_valid,
	input  wire logic                                 wr_en,
	input  wire logic [etl_pkg::REG_IDX_W-1:0]        wr_index,
	input  wire logic [etl_pkg::VAL_W-1:0]            wr_data
);
	import etl_pkg::*;

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
	localparam logic [CW-1:0] SEG_MAX  = CW'(TABLE_ENTRIES - 2);
	localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);
	// ceil(2^64 / TABLE_ENTRIES): exact quotient for spans below 2^45
	localparam logic [63:0]   STEP_RECIP =
		64'(((65'd1 << 64) + 65'(TABLE_ENTRIES - 1)) / 65'(TABLE_ENTRIES));

	typedef enum logic [4:0] {
		ST_IDLE, ST_STEP, ST_OFF, ST_ENT, ST_ENTD, ST_FWD,
		P_T2, P_T3, P_A, P_B, P_C, P_D, P_D3,
		I_RD, I_CMP, I_SEG, I_Y0, I_RX0, I_RX1, I_CHK, I_MUL, I_DIV
	} state_t;

	state_t state_q, ret_q;
	logic   go_q;

	// Configuration
	logic [TEMP_W-1:0]       melt_q, boil_q;
	logic signed [63:0]      capa_q, capb_q, capc_q, capd_q;

	// Stored build results
	logic signed [63:0]      step_q, off_q;
	logic                    ready_q;

	// Working registers
	logic signed [63:0]      pt_q, t2_q, t3_q, s_q, tmp_q, t_q;
	logic [IW-1:0]           idx_q;
	logic                    stop_q;
	logic signed [63:0]      h_q, x0_q, y0_q, diff_q, den_q;
	logic                    neg_q;
	logic [CW-1:0]           first_q, count_q;
	logic [IW-1:0]           seg_q;

	logic                    done_q, valid_q;
	logic signed [63:0]      answer_q;

	// Table memory
	logic signed [63:0]      tbl_mem [TABLE_ENTRIES];
	logic signed [63:0]      rd_q;
	logic [IW-1:0]           rd_addr;
	logic                    mem_we;
	logic [IW-1:0]           mem_waddr;
	logic signed [63:0]      mem_wdata;

	unit_req_t req;
	unit_rsp_t rsp;

	logic signed [63:0] melt_s, boil_s, span;
	logic               neg_c;
	logic signed [63:0] mul_res, div_res, mul_rnd, b_half, d_third, c_sat;
	logic signed [63:0] y0_off, ent_val, diff_c, den_c;
	logic [CW-1:0]      half, probe_full, seg_c;
	logic               stop_n, last;

	etl_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign melt_s = $signed({{(64-TEMP_W){1'b0}}, melt_q});
	assign boil_s = $signed({{(64-TEMP_W){1'b0}}, boil_q});
	assign span   = boil_s - melt_s;

	// Binary search probe and segment choice
	assign half       = count_q >> 1;
	assign probe_full = first_q + half;
	always_comb begin
		seg_c = (first_q == '0) ? '0 : first_q - CW'(1);
		if (seg_c > SEG_MAX) begin
			seg_c = SEG_MAX;
		end
		if (h_q < 0) begin
			seg_c = '0;
		end
	end

	// Result sign for the step being finished
	always_comb begin
		case (state_q)
			P_T3:    neg_c = pt_q[63];
			P_A:     neg_c = capa_q[63] ^ pt_q[63];
			P_B:     neg_c = capb_q[63];
			P_C:     neg_c = capc_q[63] ^ pt_q[63];
			P_D:     neg_c = capd_q[63] ^ t3_q[63];
			I_DIV:   neg_c = neg_q;
			default: neg_c = 1'b0;
		endcase
	end

	assign mul_res = sat_pack(neg_c, rsp.prod[95:32], |rsp.prod[127:96]);
	assign div_res = sat_pack(neg_c, rsp.quot, rsp.ovf);
	assign mul_rnd = mul_res + 64'(mul_res[63]);
	assign b_half  = mul_rnd >>> 1;
	assign d_third = tmp_q[63] ? -$signed({1'b0, rsp.prod[127:65]}) :
		$signed({1'b0, rsp.prod[127:65]});
	assign c_sat   = (capc_q > 0) ? VAL_MAX : ((capc_q < 0) ? VAL_MIN : 64'sd0);
	assign y0_off  = step_q[63] ? -$signed(rsp.prod[63:0]) : $signed(rsp.prod[63:0]);
	assign ent_val = sat_sub(s_q, off_q);
	assign diff_c  = sat_sub(h_q, x0_q);
	assign den_c   = sat_sub(rd_q, x0_q);
	assign stop_n  = stop_q | !(t_q < boil_s);
	assign last    = (idx_q == LAST_IDX);

	// Drive the shared unit
	always_comb begin
		req = '0;
		req.op = OP_MUL;
		case (state_q)
			ST_STEP: begin
				req.start = !go_q;
				req.mul_a = magn(span);
				req.mul_b = STEP_RECIP;
			end
			P_T2: begin
				req.start = !go_q;
				req.mul_a = magn(pt_q);
				req.mul_b = magn(pt_q);
			end
			P_T3: begin
				req.start = !go_q;
				req.mul_a = magn(pt_q);
				req.mul_b = magn(t2_q);
			end
			P_A: begin
				req.start = !go_q;
				req.mul_a = magn(capa_q);
				req.mul_b = magn(pt_q);
			end
			P_B: begin
				req.start = !go_q;
				req.mul_a = magn(capb_q);
				req.mul_b = magn(t2_q);
			end
			P_C: begin
				req.start    = !go_q && (pt_q != 0);
				req.op       = OP_DIV;
				req.dividend = {32'b0, magn(capc_q), 32'b0};
				req.divisor  = magn(pt_q);
			end
			P_D: begin
				req.start = !go_q;
				req.mul_a = magn(capd_q);
				req.mul_b = magn(t3_q);
			end
			P_D3: begin
				req.start = !go_q;
				req.mul_a = magn(tmp_q);
				req.mul_b = RECIP_THREE;
			end
			I_Y0: begin
				req.start = !go_q;
				req.mul_a = magn(step_q);
				req.mul_b = 64'(seg_q);
			end
			I_MUL: begin
				req.start = !go_q;
				req.mul_a = magn(diff_q);
				req.mul_b = magn(step_q);
			end
			I_DIV: begin
				req.start    = !go_q;
				req.op       = OP_DIV;
				req.dividend = rsp.prod;
				req.divisor  = magn(den_q);
			end
			default: begin
				req.start = 1'b0;
			end
		endcase
	end

	// Table read address and write port
	always_comb begin
		case (state_q)
			I_RD:    rd_addr = probe_full[IW-1:0];
			I_RX0:   rd_addr = seg_q;
			I_RX1:   rd_addr = seg_q + IW'(1);
			default: rd_addr = '0;
		endcase
		mem_we    = (state_q == ST_OFF) || (state_q == ST_ENT && stop_n) ||
			(state_q == ST_ENTD);
		mem_waddr = (state_q == ST_OFF) ? '0 : idx_q;
		mem_wdata = (state_q == ST_ENTD) ? ent_val : 64'sd0;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tbl_mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= tbl_mem[rd_addr];
	end

	// Sequencer, configuration and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ret_q    <= ST_IDLE;
			go_q     <= 1'b0;
			melt_q   <= '0;
			boil_q   <= '0;
			capa_q   <= '0;
			capb_q   <= '0;
			capc_q   <= '0;
			capd_q   <= '0;
			step_q   <= '0;
			off_q    <= '0;
			ready_q  <= 1'b0;
			pt_q     <= '0;
			t2_q     <= '0;
			t3_q     <= '0;
			s_q      <= '0;
			tmp_q    <= '0;
			t_q      <= '0;
			idx_q    <= '0;
			stop_q   <= 1'b0;
			h_q      <= '0;
			x0_q     <= '0;
			y0_q     <= '0;
			diff_q   <= '0;
			den_q    <= '0;
			neg_q    <= 1'b0;
			first_q  <= '0;
			count_q  <= '0;
			seg_q    <= '0;
			done_q   <= 1'b0;
			valid_q  <= 1'b0;
			answer_q <= '0;
		end else begin
			done_q <= 1'b0;

			// Take configuration writes
			if (wr_en) begin
				case (wr_index)
					REG_MELT: melt_q <= wr_data[TEMP_W-1:0];
					REG_BOIL: boil_q <= wr_data[TEMP_W-1:0];
					REG_CAPA: capa_q <= $signed(wr_data);
					REG_CAPB: capb_q <= $signed(wr_data);
					REG_CAPC: capc_q <= $signed(wr_data);
					REG_CAPD: capd_q <= $signed(wr_data);
					default: ;
				endcase
			end

			// Mark a unit request as issued; clear on completion
			if (req.start) begin
				go_q <= 1'b1;
			end else if (rsp.done) begin
				go_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (start) begin
						case (kind)
							KIND_BUILD: begin
								if (melt_q == '0 || boil_q == '0) begin
									ready_q  <= 1'b0;
									done_q   <= 1'b1;
									answer_q <= '0;
									valid_q  <= 1'b0;
								end else begin
									state_q <= ST_STEP;
								end
							end
							KIND_INV: begin
								if (ready_q) begin
									h_q     <= query_value;
									first_q <= '0;
									count_q <= FULL_CNT;
									state_q <= I_RD;
								end else begin
									done_q   <= 1'b1;
									answer_q <= '0;
									valid_q  <= 1'b0;
								end
							end
							KIND_FWD: begin
								if (ready_q) begin
									pt_q    <= query_value;
									ret_q   <= ST_FWD;
									state_q <= P_T2;
								end else begin
									done_q   <= 1'b1;
									answer_q <= '0;
									valid_q  <= 1'b0;
								end
							end
							default: begin
								done_q   <= 1'b1;
								answer_q <= '0;
								valid_q  <= 1'b0;
							end
						endcase
					end
				end

				// Build: step, offset, then one entry at a time
				ST_STEP: begin
					if (rsp.done) begin
						step_q  <= span[63] ? -$signed(rsp.prod[127:64]) :
							$signed(rsp.prod[127:64]);
						pt_q    <= melt_s;
						ret_q   <= ST_OFF;
						state_q <= P_T2;
					end
				end
				ST_OFF: begin
					off_q   <= s_q;
					idx_q   <= IW'(1);
					t_q     <= melt_s + step_q;
					stop_q  <= 1'b0;
					state_q <= ST_ENT;
				end
				ST_ENT: begin
					if (stop_n) begin
						stop_q <= 1'b1;
						if (last) begin
							ready_q  <= 1'b1;
							done_q   <= 1'b1;
							answer_q <= '0;
							valid_q  <= 1'b1;
							state_q  <= ST_IDLE;
						end else begin
							idx_q <= idx_q + IW'(1);
							t_q   <= t_q + step_q;
						end
					end else begin
						pt_q    <= t_q;
						ret_q   <= ST_ENTD;
						state_q <= P_T2;
					end
				end
				ST_ENTD: begin
					if (last) begin
						ready_q  <= 1'b1;
						done_q   <= 1'b1;
						answer_q <= '0;
						valid_q  <= 1'b1;
						state_q  <= ST_IDLE;
					end else begin
						idx_q   <= idx_q + IW'(1);
						t_q     <= t_q + step_q;
						state_q <= ST_ENT;
					end
				end
				ST_FWD: begin
					done_q   <= 1'b1;
					answer_q <= ent_val;
					valid_q  <= 1'b1;
					state_q  <= ST_IDLE;
				end

				// Polynomial evaluation at pt_q into s_q
				P_T2: begin
					if (rsp.done) begin
						t2_q    <= mul_res;
						state_q <= P_T3;
					end
				end
				P_T3: begin
					if (rsp.done) begin
						t3_q    <= mul_res;
						state_q <= P_A;
					end
				end
				P_A: begin
					if (rsp.done) begin
						s_q     <= mul_res;
						state_q <= P_B;
					end
				end
				P_B: begin
					if (rsp.done) begin
						s_q     <= sat_add(s_q, b_half);
						state_q <= P_C;
					end
				end
				P_C: begin
					if (pt_q == 0) begin
						s_q     <= sat_sub(s_q, c_sat);
						state_q <= P_D;
					end else if (rsp.done) begin
						s_q     <= sat_sub(s_q, div_res);
						state_q <= P_D;
					end
				end
				P_D: begin
					if (rsp.done) begin
						tmp_q   <= mul_res;
						state_q <= P_D3;
					end
				end
				P_D3: begin
					if (rsp.done) begin
						s_q     <= sat_add(s_q, d_third);
						state_q <= ret_q;
					end
				end

				// Inverse: lower-bound search, then interpolate
				I_RD: begin
					if (count_q == '0) begin
						state_q <= I_SEG;
					end else begin
						state_q <= I_CMP;
					end
				end
				I_CMP: begin
					if (rd_q < h_q) begin
						first_q <= probe_full + CW'(1);
						count_q <= count_q - half - CW'(1);
					end else begin
						count_q <= half;
					end
					state_q <= I_RD;
				end
				I_SEG: begin
					seg_q   <= seg_c[IW-1:0];
					state_q <= I_Y0;
				end
				I_Y0: begin
					if (rsp.done) begin
						y0_q    <= melt_s + y0_off;
						state_q <= I_RX0;
					end
				end
				I_RX0: begin
					state_q <= I_RX1;
				end
				I_RX1: begin
					x0_q    <= rd_q;
					state_q <= I_CHK;
				end
				I_CHK: begin
					if (rd_q == x0_q) begin
						done_q   <= 1'b1;
						answer_q <= y0_q;
						valid_q  <= 1'b1;
						state_q  <= ST_IDLE;
					end else begin
						diff_q  <= diff_c;
						den_q   <= den_c;
						neg_q   <= diff_c[63] ^ step_q[63] ^ den_c[63];
						state_q <= I_MUL;
					end
				end
				I_MUL: begin
					if (rsp.done) begin
						state_q <= I_DIV;
					end
				end
				I_DIV: begin
					if (rsp.done) begin
						done_q   <= 1'b1;
						answer_q <= sat_add(y0_q, div_res);
						valid_q  <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign answer       = answer_q;
	assign answer_valid = valid_q;

endmodule
`default_nettype wire

@@ hdl/etl_checker.sv @@
// Port-level checks for the enthalpy table core, bound to the top level.
// Depends on enthalpy_temperature_table_lookup_core.
`default_nettype none
module etl_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [63:0] answer,
	input wire logic        answer_valid
);

	// An accepted transaction either answers at once or holds busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted transaction neither answered nor busy");

	// A result leaves the core idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// Busy ends only with a result
	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// An invalid result carries zero
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !answer_valid |-> answer == 64'd0)
		else $error("invalid result with nonzero answer");

endmodule

bind enthalpy_temperature_table_lookup_core etl_checker u_etl_checker (.*);
`default_nettype wire
